>>> hdl/assert_macros.svh
// Assertion helper macros for the FSK frame tone sequencer.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define FTS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fts: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define FTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fts: next-cycle check failed");

`endif

>>> hdl/fts_pkg.sv
// Shared types, codes and sizing constants for the FSK frame tone sequencer.
// No dependencies; used by every module of the block.
package fts_pkg;

  // Sizing limits of the sequencer.
  localparam int MAX_DATA_BITS = 32;
  localparam int MAX_IDLE_BITS = 32;
  localparam int QUEUE_DEPTH   = 2;

  // Field widths fixed by the interface.
  localparam int OP_W    = 2;
  localparam int WORD_W  = 32;
  localparam int HZ_W    = 16;
  localparam int DUR_W   = 18;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 16;
  localparam int REG_W   = 3;
  localparam int BITS_W  = 6;
  localparam int HALF_W  = 4;
  localparam int MODE_W  = 2;

  // Derived widths.
  localparam int CNT_MAX  = (MAX_DATA_BITS > MAX_IDLE_BITS) ? MAX_DATA_BITS : MAX_IDLE_BITS;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam int SH_W     = (MAX_DATA_BITS > WORD_W) ? MAX_DATA_BITS : WORD_W;
  localparam int SHAMT_W  = $clog2(SH_W + 1);
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W   = HZ_W + HALF_W;

  // Request codes.
  localparam logic [OP_W-1:0] OP_LEADER  = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
  localparam logic [OP_W-1:0] OP_TRAILER = 2'd2;

  // Segment kinds.
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd3;

  // Register indexes.
  localparam logic [REG_W-1:0] REG_DATA_BITS   = 3'd0;
  localparam logic [REG_W-1:0] REG_START_HALF  = 3'd1;
  localparam logic [REG_W-1:0] REG_STOP_HALF   = 3'd2;
  localparam logic [REG_W-1:0] REG_BIT_SAMPLES = 3'd3;
  localparam logic [REG_W-1:0] REG_MARK_HZ     = 3'd4;
  localparam logic [REG_W-1:0] REG_SPACE_HZ    = 3'd5;
  localparam logic [REG_W-1:0] REG_FRAME_MODE  = 3'd6;
  localparam logic [REG_W-1:0] REG_IDLE_BITS   = 3'd7;

  // Configuration register contents as seen by the front and back ends.
  typedef struct packed {
    logic [BITS_W-1:0] data_bits;
    logic [HALF_W-1:0] start_half_bits;
    logic [HALF_W-1:0] stop_half_bits;
    logic [HZ_W-1:0]   bit_samples;
    logic [HZ_W-1:0]   mark_hz;
    logic [HZ_W-1:0]   space_hz;
    logic [MODE_W-1:0] frame_mode;
    logic [BITS_W-1:0] idle_bits;
  } fts_cfg_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic             is_frame;
    logic             has_start;
    logic             has_stop;
    logic             msb_first;
    logic [CNT_W-1:0] cnt;
    logic [SH_W-1:0]  word;
  } fts_entry_t;

endpackage

>>> hdl/fts_front.sv
// Front end: accepts requests, drops those that give no segment, and
// prepares a queue entry. Depends on fts_pkg.
module fts_front (
  input  logic                              start,
  input  logic                              q_full,
  input  logic [fts_pkg::OP_W-1:0]          in_op,
  input  logic [fts_pkg::WORD_W-1:0]        in_data_word,
  input  fts_pkg::fts_cfg_t                 cfg,
  output logic                              busy,
  output logic                              push,
  output fts_pkg::fts_entry_t               entry
);

  logic [fts_pkg::CNT_W-1:0]   nb;
  logic [fts_pkg::CNT_W-1:0]   ni;
  logic [fts_pkg::SH_W-1:0]    word_ext;
  logic [fts_pkg::SHAMT_W-1:0] shamt;
  logic                        has_any;

  // The front stalls only when the queue has no room.
  assign busy = q_full;

  // Saturate the counts and align the data word for the chosen bit order.
  always_comb begin
    nb = (int'(cfg.data_bits) > fts_pkg::MAX_DATA_BITS) ?
         fts_pkg::CNT_W'(fts_pkg::MAX_DATA_BITS) : fts_pkg::CNT_W'(cfg.data_bits);
    ni = (int'(cfg.idle_bits) > fts_pkg::MAX_IDLE_BITS) ?
         fts_pkg::CNT_W'(fts_pkg::MAX_IDLE_BITS) : fts_pkg::CNT_W'(cfg.idle_bits);
    word_ext = fts_pkg::SH_W'(in_data_word);
    shamt    = fts_pkg::SHAMT_W'(fts_pkg::SH_W - int'(nb));
  end

  // Classify the request and build the entry.
  always_comb begin
    entry.has_start = (cfg.start_half_bits != '0);
    entry.has_stop  = (cfg.stop_half_bits != '0);
    entry.msb_first = cfg.frame_mode[1];
    entry.word      = cfg.frame_mode[1] ? (word_ext << shamt) : word_ext;
    entry.is_frame  = 1'b0;
    entry.cnt       = ni;
    has_any         = 1'b0;
    unique case (in_op)
      fts_pkg::OP_LEADER, fts_pkg::OP_TRAILER: begin
        has_any = (ni != '0);
      end
      fts_pkg::OP_FRAME: begin
        entry.is_frame = 1'b1;
        entry.cnt      = nb;
        has_any        = entry.has_start || entry.has_stop || (nb != '0);
      end
      default: begin
        has_any = 1'b0;
      end
    endcase
    push = start && !q_full && has_any;
  end

endmodule

>>> hdl/fts_queue.sv
// Short queue of classified requests between the front and back ends.
// Depends on fts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fts_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fts_pkg::fts_entry_t push_entry,
  input  logic                pop,
  output logic                q_valid,
  output logic                q_full,
  output fts_pkg::fts_entry_t q_entry
);

  fts_pkg::fts_entry_t              mem_r [fts_pkg::QUEUE_DEPTH];
  logic [fts_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [fts_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [fts_pkg::QCNT_W-1:0]       cnt_r;
  logic [fts_pkg::QPTR_W-1:0]       wr_ptr_nxt;
  logic [fts_pkg::QPTR_W-1:0]       rd_ptr_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == fts_pkg::QCNT_W'(fts_pkg::QUEUE_DEPTH));
  assign q_entry = mem_r[rd_ptr_r];

  // Pointer wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == fts_pkg::QPTR_W'(fts_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == fts_pkg::QPTR_W'(fts_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_r + 1'b1;
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `FTS_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, push, !q_full || pop)
  `FTS_ASSERT_IMPLIES(a_fill_in_range, clk, rst_n, 1'b1, cnt_r <= fts_pkg::QCNT_W'(fts_pkg::QUEUE_DEPTH))
  `FTS_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, q_valid)

endmodule

>>> hdl/fts_back.sv
// Back end: walks one queued request through its segments, one per cycle,
// and drives the registered result word. Depends on fts_pkg, assert_macros.svh.
`include "assert_macros.svh"

module fts_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fts_pkg::fts_cfg_t                cfg,
  input  logic                             q_valid,
  input  fts_pkg::fts_entry_t              q_entry,
  output logic                             pop,
  output logic                             out_valid,
  output logic [fts_pkg::HZ_W-1:0]         out_tone_hz,
  output logic [fts_pkg::DUR_W-1:0]        out_duration_samples,
  output logic [fts_pkg::KIND_W-1:0]       out_segment_kind,
  output logic                             out_last
);

  typedef enum logic [1:0] {
    PH_START,
    PH_DATA,
    PH_STOP,
    PH_IDLE
  } phase_t;

  phase_t                        phase_r;
  logic                          act_r;
  logic [fts_pkg::CNT_W-1:0]     cnt_r;
  logic [fts_pkg::SH_W-1:0]      word_r;
  logic                          msb_r;
  logic                          has_stop_r;
  logic                          out_valid_r;
  logic [fts_pkg::HZ_W-1:0]      out_tone_hz_r;
  logic [fts_pkg::DUR_W-1:0]     out_duration_r;
  logic [fts_pkg::KIND_W-1:0]    out_kind_r;
  logic                          out_last_r;

  logic                          seg_bit;
  logic [fts_pkg::HZ_W-1:0]      seg_hz;
  logic [fts_pkg::DUR_W-1:0]     seg_dur;
  logic [fts_pkg::KIND_W-1:0]    seg_kind;
  logic                          seg_last;
  logic [fts_pkg::PROD_W-1:0]    start_prod;
  logic [fts_pkg::PROD_W-1:0]    stop_prod;
  phase_t                        load_phase;

  // Half-bit lengths, truncated to whole samples.
  assign start_prod = fts_pkg::PROD_W'(cfg.bit_samples) * fts_pkg::PROD_W'(cfg.start_half_bits);
  assign stop_prod  = fts_pkg::PROD_W'(cfg.bit_samples) * fts_pkg::PROD_W'(cfg.stop_half_bits);

  // Current data bit sits at the end the word shifts out of.
  assign seg_bit = msb_r ? word_r[fts_pkg::SH_W-1] : word_r[0];

  // Segment fields for the current phase.
  always_comb begin
    unique case (phase_r)
      PH_START: begin
        seg_hz   = cfg.frame_mode[0] ? cfg.mark_hz : cfg.space_hz;
        seg_dur  = fts_pkg::DUR_W'(start_prod >> 1);
        seg_kind = fts_pkg::KIND_START;
        seg_last = (cnt_r == '0) && !has_stop_r;
      end
      PH_DATA: begin
        seg_hz   = seg_bit ? cfg.mark_hz : cfg.space_hz;
        seg_dur  = fts_pkg::DUR_W'(cfg.bit_samples);
        seg_kind = fts_pkg::KIND_DATA;
        seg_last = (cnt_r == fts_pkg::CNT_W'(1)) && !has_stop_r;
      end
      PH_STOP: begin
        seg_hz   = cfg.frame_mode[0] ? cfg.space_hz : cfg.mark_hz;
        seg_dur  = fts_pkg::DUR_W'(stop_prod >> 1);
        seg_kind = fts_pkg::KIND_STOP;
        seg_last = 1'b1;
      end
      PH_IDLE: begin
        seg_hz   = cfg.mark_hz;
        seg_dur  = fts_pkg::DUR_W'(cfg.bit_samples);
        seg_kind = fts_pkg::KIND_IDLE;
        seg_last = (cnt_r == fts_pkg::CNT_W'(1));
      end
      default: begin
        seg_hz   = cfg.mark_hz;
        seg_dur  = '0;
        seg_kind = fts_pkg::KIND_IDLE;
        seg_last = 1'b1;
      end
    endcase
  end

  // First phase of a newly loaded request.
  always_comb begin
    priority if (!q_entry.is_frame) begin
      load_phase = PH_IDLE;
    end else if (q_entry.has_start) begin
      load_phase = PH_START;
    end else if (q_entry.cnt != '0) begin
      load_phase = PH_DATA;
    end else begin
      load_phase = PH_STOP;
    end
  end

  // Take the next request when idle or on the last segment of this one.
  assign pop = q_valid && (!act_r || seg_last);

  // Sequencer state and registered result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= act_r;
      if (act_r) begin
        out_tone_hz_r  <= seg_hz;
        out_duration_r <= seg_dur;
        out_kind_r     <= seg_kind;
        out_last_r     <= seg_last;
      end
      if (pop) begin
        act_r      <= 1'b1;
        phase_r    <= load_phase;
        cnt_r      <= q_entry.cnt;
        word_r     <= q_entry.word;
        msb_r      <= q_entry.msb_first;
        has_stop_r <= q_entry.has_stop;
      end else if (act_r) begin
        if (seg_last) begin
          act_r <= 1'b0;
        end else begin
          unique case (phase_r)
            PH_START: begin
              phase_r <= (cnt_r != '0) ? PH_DATA : PH_STOP;
            end
            PH_DATA: begin
              cnt_r  <= cnt_r - 1'b1;
              word_r <= msb_r ? (word_r << 1) : (word_r >> 1);
              if (cnt_r == fts_pkg::CNT_W'(1)) begin
                phase_r <= PH_STOP;
              end
            end
            PH_IDLE: begin
              cnt_r <= cnt_r - 1'b1;
            end
            default: begin
              act_r <= 1'b0;
            end
          endcase
        end
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tone_hz          = out_tone_hz_r;
  assign out_duration_samples = out_duration_r;
  assign out_segment_kind     = out_kind_r;
  assign out_last             = out_last_r;

  `FTS_ASSERT_NEXT(a_stop_ends_request, clk, rst_n, act_r && phase_r == PH_STOP, out_valid && out_last)
  `FTS_ASSERT_IMPLIES(a_data_has_bits, clk, rst_n, act_r && phase_r == PH_DATA, cnt_r != '0)
  `FTS_ASSERT_IMPLIES(a_idle_has_bits, clk, rst_n, act_r && phase_r == PH_IDLE, cnt_r != '0)

endmodule

>>> hdl/fsk_frame_tone_sequencer.sv
// FSK frame tone sequencer: top level with configuration registers.
// Depends on fts_pkg, fts_front, fts_queue and fts_back.
//
// Usage:
//   A request (in_op, in_data_word) is taken at a rising edge where start is
//   high and busy is low. A leader or trailer request gives idle_bits mark
//   segments of one bit time; a data request gives an asynchronous serial
//   frame: optional start segment, one segment per data bit, optional stop.
//   Each segment appears on the out_ ports for exactly one cycle with
//   out_valid high; out_last marks the final segment of a request. The
//   receiver cannot hold segments off, and none is ever needed to be held.
//   An accepted request is written to the queue, then loaded into the
//   back-end segment walker; each segment is registered before it is driven.
//   Throughput: one segment per cycle, set by the back-end segment walker;
//   a frame gives up to 34 segments (start, 32 data bits, stop).
//   A two-entry queue between front and back lets new requests be taken
//   while earlier ones are still being sent; busy is high while it is full.
//   Requests that give no segment (op 3, empty frame, zero idle bits) are
//   dropped at the front. Reset clears the queue and the sequencer and loads
//   the default register values; the user must write registers through cfg_we,
//   cfg_index and cfg_data only while no request is in flight; not enforced.
module fsk_frame_tone_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fts_pkg::OP_W-1:0]      in_op,
  input  logic [fts_pkg::WORD_W-1:0]    in_data_word,
  output logic                          out_valid,
  output logic [fts_pkg::HZ_W-1:0]      out_tone_hz,
  output logic [fts_pkg::DUR_W-1:0]     out_duration_samples,
  output logic [fts_pkg::KIND_W-1:0]    out_segment_kind,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [fts_pkg::REG_W-1:0]     cfg_index,
  input  logic [fts_pkg::CFG_W-1:0]     cfg_data
);

  fts_pkg::fts_cfg_t   cfg_r;
  fts_pkg::fts_entry_t push_entry;
  fts_pkg::fts_entry_t q_entry;
  logic                push;
  logic                pop;
  logic                q_valid;
  logic                q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_bits       <= fts_pkg::BITS_W'(8);
      cfg_r.start_half_bits <= fts_pkg::HALF_W'(2);
      cfg_r.stop_half_bits  <= fts_pkg::HALF_W'(2);
      cfg_r.bit_samples     <= fts_pkg::HZ_W'(40);
      cfg_r.mark_hz         <= fts_pkg::HZ_W'(1200);
      cfg_r.space_hz        <= fts_pkg::HZ_W'(2200);
      cfg_r.frame_mode      <= '0;
      cfg_r.idle_bits       <= fts_pkg::BITS_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fts_pkg::REG_DATA_BITS:   cfg_r.data_bits       <= cfg_data[fts_pkg::BITS_W-1:0];
        fts_pkg::REG_START_HALF:  cfg_r.start_half_bits <= cfg_data[fts_pkg::HALF_W-1:0];
        fts_pkg::REG_STOP_HALF:   cfg_r.stop_half_bits  <= cfg_data[fts_pkg::HALF_W-1:0];
        fts_pkg::REG_BIT_SAMPLES: cfg_r.bit_samples     <= cfg_data[fts_pkg::HZ_W-1:0];
        fts_pkg::REG_MARK_HZ:     cfg_r.mark_hz         <= cfg_data[fts_pkg::HZ_W-1:0];
        fts_pkg::REG_SPACE_HZ:    cfg_r.space_hz        <= cfg_data[fts_pkg::HZ_W-1:0];
        fts_pkg::REG_FRAME_MODE:  cfg_r.frame_mode      <= cfg_data[fts_pkg::MODE_W-1:0];
        fts_pkg::REG_IDLE_BITS:   cfg_r.idle_bits       <= cfg_data[fts_pkg::BITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request classification.
  fts_front u_front (
    .start        (start),
    .q_full       (q_full),
    .in_op        (in_op),
    .in_data_word (in_data_word),
    .cfg          (cfg_r),
    .busy         (busy),
    .push         (push),
    .entry        (push_entry)
  );

  // Queue between front and back.
  fts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .q_entry    (q_entry)
  );

  // Segment walker and result register.
  fts_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_entry              (q_entry),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_tone_hz          (out_tone_hz),
    .out_duration_samples (out_duration_samples),
    .out_segment_kind     (out_segment_kind),
    .out_last             (out_last)
  );

endmodule
